// ===== rtl/sgi_pkg.sv =====
// Shared constants, command codes, datapath operations and handshake structs.
package sgi_pkg;

  localparam int unsigned MaxPattern = 16;
  localparam int unsigned MaxTarget  = 32;

  localparam int unsigned PvW        = $clog2(MaxPattern);
  localparam int unsigned TvW        = $clog2(MaxTarget);
  localparam int unsigned DepthW     = $clog2(MaxPattern + 1);
  localparam int unsigned StackDepth = (MaxPattern + 1) * MaxPattern;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned PDegW      = $clog2(MaxPattern + 1);
  localparam int unsigned TDegW      = $clog2(MaxTarget + 1);

  localparam int unsigned PnW        = 5;
  localparam int unsigned TnW        = 6;
  localparam int unsigned CmdW       = 3;
  localparam int unsigned VertW      = 5;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 6;
  localparam int unsigned OutPvW     = 4;
  localparam int unsigned OutTvW     = 5;

  localparam logic [CmdW-1:0] CmdPatternEdge = 3'd0;
  localparam logic [CmdW-1:0] CmdTargetEdge  = 3'd1;
  localparam logic [CmdW-1:0] CmdStart       = 3'd2;
  localparam logic [CmdW-1:0] CmdNext        = 3'd3;
  localparam logic [CmdW-1:0] CmdClear       = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgPatternVertices = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTargetVertices  = 1'b1;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_PDEG,
    OP_TDEG,
    OP_ORD_INIT,
    OP_ORD_STEP,
    OP_ORD_COMMIT,
    OP_SEED,
    OP_PASS_INIT,
    OP_ROW_RD,
    OP_ROW_LATCH,
    OP_NB_RD,
    OP_NB_ACC,
    OP_ROW_DONE,
    OP_CH_RD,
    OP_CH_PICK,
    OP_BACK,
    OP_DESCEND,
    OP_COPY_RD,
    OP_COPY_WR,
    OP_DEPTH_INC,
    OP_EMIT_PAIR,
    OP_EMIT_EXH
  } dp_op_e;

  typedef struct packed {
    dp_op_e         op;
    logic [TvW-1:0] idx;
    logic [PvW-1:0] sub;
  } dp_cmd_t;

  typedef struct packed {
    logic [PnW-1:0]    pn;
    logic [TnW-1:0]    tn;
    logic [DepthW-1:0] depth;
    logic              pn_gt_tn;
    logic              active;
    logic              row_fail;
    logic              changed_any;
    logic              k_found;
    logic              last_level;
    logic              out_free;
  } dp_status_t;

  function automatic logic [PDegW-1:0] pop_pattern(input logic [MaxPattern-1:0] x);
    logic [PDegW-1:0] c;
    c = '0;
    for (int i = 0; i < MaxPattern; i++) c = c + PDegW'(x[i]);
    return c;
  endfunction

  function automatic logic [TDegW-1:0] pop_target(input logic [MaxTarget-1:0] x);
    logic [TDegW-1:0] c;
    c = '0;
    for (int i = 0; i < MaxTarget; i++) c = c + TDegW'(x[i]);
    return c;
  endfunction

endpackage

// ===== rtl/subgraph_isomorphism_search.sv =====
// Edge load, clear and unused commands give no result.
// Start: pattern degrees, target degrees, visit order and seed rows are set up, then the search;
// each refinement pass is paced by the single read port of the candidate stack.
// Choose reads a row then picks; descend copies the level up; results leave one per cycle unstalled.
// One command at a time; the next is taken once the last result is registered.
// Reset: clears both adjacency stores, sets both vertex counts to 1; no clearing pass.
module subgraph_isomorphism_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sgi_pkg::CmdW-1:0]      cmd_i,
  input  logic [sgi_pkg::VertW-1:0]     vertex_a_i,
  input  logic [sgi_pkg::VertW-1:0]     vertex_b_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic [sgi_pkg::OutPvW-1:0]    pattern_vertex_o,
  output logic [sgi_pkg::OutTvW-1:0]    target_vertex_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sgi_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sgi_pkg::CfgDataW-1:0]  cfg_data_i
);
  import sgi_pkg::*;

  dp_cmd_t    ctl;
  dp_status_t status;

  sgi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .cfg_ready_o (cfg_ready_o),
    .status_i    (status),
    .ctl_o       (ctl)
  );

  sgi_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .status_o         (status),
    .cmd_i            (cmd_i),
    .vertex_a_i       (vertex_a_i),
    .vertex_b_i       (vertex_b_i),
    .cfg_write_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .kind_o           (kind_o),
    .pattern_vertex_o (pattern_vertex_o),
    .target_vertex_o  (target_vertex_o),
    .last_o           (last_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(status.depth) <= MaxPattern)
    else $error("search depth beyond pattern size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.op == OP_EMIT_PAIR |-> status.depth == DepthW'(status.pn))
    else $error("mapping emitted before every pattern vertex is placed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> last_o)
    else $error("exhausted transaction without last");

endmodule

// ===== rtl/sgi_ctrl.sv =====
// Search sequencer: one-hot state machine and loop counters.
module sgi_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [sgi_pkg::CmdW-1:0] cmd_i,
  output logic                     cfg_ready_o,
  input  sgi_pkg::dp_status_t      status_i,
  output sgi_pkg::dp_cmd_t         ctl_o
);
  import sgi_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE      = 22'h000001,
    S_PDEG      = 22'h000002,
    S_TDEG      = 22'h000004,
    S_ORD_INIT  = 22'h000008,
    S_ORD_STEP  = 22'h000010,
    S_ORD_COMMIT = 22'h000020,
    S_SEED      = 22'h000040,
    S_PASS_INIT = 22'h000080,
    S_ROW_RD    = 22'h000100,
    S_ROW_LATCH = 22'h000200,
    S_NB_RD     = 22'h000400,
    S_NB_ACC    = 22'h000800,
    S_ROW_DONE  = 22'h001000,
    S_CH_RD     = 22'h002000,
    S_CH_PICK   = 22'h004000,
    S_BACK      = 22'h008000,
    S_DESCEND   = 22'h010000,
    S_COPY_RD   = 22'h020000,
    S_COPY_WR   = 22'h040000,
    S_DEPTH_INC = 22'h080000,
    S_EMIT_PAIR = 22'h100000,
    S_EMIT_EXH  = 22'h200000
  } state_e;

  state_e         state_q, state_d;
  logic [TvW-1:0] idx_q, idx_d;
  logic [PvW-1:0] sub_q, sub_d;
  logic [PnW-1:0] pn_m1;
  logic [TnW-1:0] tn_m1;
  logic           idx_pn_last, idx_tn_last, sub_last, accept;

  assign pn_m1       = status_i.pn - 1'b1;
  assign tn_m1       = status_i.tn - 1'b1;
  assign idx_pn_last = (idx_q == TvW'(pn_m1));
  assign idx_tn_last = (TnW'(idx_q) == tn_m1);
  assign sub_last    = (sub_q == PvW'(pn_m1));

  assign in_stall_o  = (state_q != S_IDLE);
  // Hold register writes off while a command transaction is offered
  assign cfg_ready_o = (state_q == S_IDLE) && !in_valid_i;
  assign accept      = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    sub_d     = sub_q;
    ctl_o.op  = OP_NOP;
    ctl_o.idx = idx_q;
    ctl_o.sub = sub_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctl_o.op = OP_LOAD;
          idx_d    = '0;
          sub_d    = '0;
          if (cmd_i == CmdStart) begin
            state_d = status_i.pn_gt_tn ? S_EMIT_EXH : S_PDEG;
          end else if (cmd_i == CmdNext) begin
            state_d = status_i.active ? S_PASS_INIT : S_EMIT_EXH;
          end
        end
      end
      S_PDEG: begin
        ctl_o.op = OP_PDEG;
        if (idx_pn_last) begin
          idx_d   = '0;
          state_d = S_TDEG;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_TDEG: begin
        ctl_o.op = OP_TDEG;
        if (idx_tn_last) begin
          idx_d   = '0;
          state_d = S_ORD_INIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_ORD_INIT: begin
        ctl_o.op = OP_ORD_INIT;
        sub_d    = '0;
        state_d  = S_ORD_STEP;
      end
      S_ORD_STEP: begin
        ctl_o.op = OP_ORD_STEP;
        if (sub_last) state_d = S_ORD_COMMIT;
        else sub_d = sub_q + 1'b1;
      end
      S_ORD_COMMIT: begin
        ctl_o.op = OP_ORD_COMMIT;
        if (idx_pn_last) begin
          idx_d   = '0;
          state_d = S_SEED;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_ORD_INIT;
        end
      end
      S_SEED: begin
        ctl_o.op = OP_SEED;
        if (idx_pn_last) state_d = S_PASS_INIT;
        else idx_d = idx_q + 1'b1;
      end
      S_PASS_INIT: begin
        ctl_o.op = OP_PASS_INIT;
        idx_d    = '0;
        state_d  = S_ROW_RD;
      end
      S_ROW_RD: begin
        ctl_o.op = OP_ROW_RD;
        state_d  = S_ROW_LATCH;
      end
      S_ROW_LATCH: begin
        ctl_o.op = OP_ROW_LATCH;
        sub_d    = '0;
        state_d  = S_NB_RD;
      end
      S_NB_RD: begin
        ctl_o.op = OP_NB_RD;
        state_d  = S_NB_ACC;
      end
      S_NB_ACC: begin
        ctl_o.op = OP_NB_ACC;
        if (sub_last) begin
          state_d = S_ROW_DONE;
        end else begin
          sub_d   = sub_q + 1'b1;
          state_d = S_NB_RD;
        end
      end
      S_ROW_DONE: begin
        ctl_o.op = OP_ROW_DONE;
        priority if (status_i.row_fail) begin
          state_d = S_BACK;
        end else if (idx_pn_last) begin
          state_d = status_i.changed_any ? S_PASS_INIT : S_CH_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_ROW_RD;
        end
      end
      S_CH_RD: begin
        ctl_o.op = OP_CH_RD;
        state_d  = S_CH_PICK;
      end
      S_CH_PICK: begin
        ctl_o.op = OP_CH_PICK;
        state_d  = status_i.k_found ? S_DESCEND : S_BACK;
      end
      S_BACK: begin
        ctl_o.op = OP_BACK;
        state_d  = (status_i.depth == '0) ? S_EMIT_EXH : S_PASS_INIT;
      end
      S_DESCEND: begin
        ctl_o.op = OP_DESCEND;
        idx_d    = '0;
        state_d  = S_COPY_RD;
      end
      S_COPY_RD: begin
        ctl_o.op = OP_COPY_RD;
        state_d  = S_COPY_WR;
      end
      S_COPY_WR: begin
        ctl_o.op = OP_COPY_WR;
        if (idx_pn_last) begin
          state_d = S_DEPTH_INC;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_COPY_RD;
        end
      end
      S_DEPTH_INC: begin
        ctl_o.op = OP_DEPTH_INC;
        idx_d    = '0;
        state_d  = status_i.last_level ? S_EMIT_PAIR : S_PASS_INIT;
      end
      S_EMIT_PAIR: begin
        ctl_o.op = OP_EMIT_PAIR;
        if (status_i.out_free) begin
          if (idx_pn_last) state_d = S_IDLE;
          else idx_d = idx_q + 1'b1;
        end
      end
      S_EMIT_EXH: begin
        ctl_o.op = OP_EMIT_EXH;
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sub_q   <= sub_d;
    end
  end

endmodule

// ===== rtl/sgi_dpath.sv =====
// Datapath: adjacency stores, candidate stack memory, search registers, result register.
module sgi_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sgi_pkg::dp_cmd_t              ctl_i,
  output sgi_pkg::dp_status_t           status_o,
  input  logic [sgi_pkg::CmdW-1:0]      cmd_i,
  input  logic [sgi_pkg::VertW-1:0]     vertex_a_i,
  input  logic [sgi_pkg::VertW-1:0]     vertex_b_i,
  input  logic                          cfg_write_i,
  input  logic [sgi_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sgi_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic                          kind_o,
  output logic [sgi_pkg::OutPvW-1:0]    pattern_vertex_o,
  output logic [sgi_pkg::OutTvW-1:0]    target_vertex_o,
  output logic                          last_o
);
  import sgi_pkg::*;

  logic [PnW-1:0]          pn_cfg_q, pn_eff;
  logic [TnW-1:0]          tn_cfg_q, tn_eff;
  logic [MaxPattern-1:0]   padj_q [MaxPattern];
  logic [MaxTarget-1:0]    tadj_q [MaxTarget];
  logic [PDegW-1:0]        pdeg_q [MaxPattern];
  logic [TDegW-1:0]        tdeg_q [MaxTarget];
  logic [PvW-1:0]          visit_q [MaxPattern];
  logic [TvW-1:0]          chosen_q [MaxPattern];
  logic [MaxPattern-1:0]   taken_q;
  logic [PvW-1:0]          best_q;
  logic [PDegW-1:0]        bdeg_q;
  logic                    have_q;
  logic [MaxTarget-1:0]    used_q;
  logic [DepthW-1:0]       depth_q;
  logic [TvW-1:0]          cur_q;
  logic                    cur_none_q;
  logic                    active_q;
  logic [PvW-1:0]          v_q;
  logic [MaxTarget-1:0]    rowv_q, ok_q;
  logic                    changed_q;
  logic [TvW-1:0]          k_q;
  logic [MaxTarget-1:0]    mem [StackDepth];
  logic [MaxTarget-1:0]    rdata_q;
  logic                    out_valid_q, kind_q, last_q;
  logic [OutPvW-1:0]       pv_q;
  logic [OutTvW-1:0]       tv_q;

  logic [MaxPattern:0]     pm_full;
  logic [MaxTarget:0]      tm_full;
  logic [MaxPattern-1:0]   pm, nb;
  logic [MaxTarget-1:0]    tm, okv, newrow, above, cand, iso, seed_row, wdata;
  logic [PvW-1:0]          idx_p, vd, back_v;
  logic [DepthW-1:0]       back_d;
  logic [TvW-1:0]          k_enc, back_c;
  logic [AddrW-1:0]        raddr, waddr;
  logic                    we, out_free, row_changed;

  // Clamp configured counts into their legal ranges.
  always_comb begin
    if (pn_cfg_q == '0) pn_eff = PnW'(1);
    else if (int'(pn_cfg_q) > MaxPattern) pn_eff = PnW'(MaxPattern);
    else pn_eff = pn_cfg_q;
    if (tn_cfg_q == '0) tn_eff = TnW'(1);
    else if (int'(tn_cfg_q) > MaxTarget) tn_eff = TnW'(MaxTarget);
    else tn_eff = tn_cfg_q;
  end

  assign pm_full = ({{MaxPattern{1'b0}}, 1'b1} << pn_eff) - 1'b1;
  assign tm_full = ({{MaxTarget{1'b0}}, 1'b1} << tn_eff) - 1'b1;
  assign pm      = pm_full[MaxPattern-1:0];
  assign tm      = tm_full[MaxTarget-1:0];

  assign idx_p   = ctl_i.idx[PvW-1:0];
  assign vd      = visit_q[depth_q[PvW-1:0]];
  assign nb      = padj_q[v_q] & pm;
  assign newrow  = rowv_q & ok_q;
  assign row_changed = (newrow != rowv_q);
  assign back_d  = depth_q - 1'b1;
  assign back_v  = visit_q[back_d[PvW-1:0]];
  assign back_c  = chosen_q[back_v];
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    for (int j = 0; j < MaxTarget; j++) begin
      okv[j]      = |(rdata_q & tadj_q[j] & tm);
      seed_row[j] = tm[j] && (TDegW'(pdeg_q[idx_p]) <= tdeg_q[j]);
    end
  end

  // Next free column above the last one tried.
  assign above = cur_none_q ? '1 : (({MaxTarget{1'b1}} << cur_q) << 1);
  assign cand  = rdata_q & ~used_q & tm & above;
  assign iso   = cand & (~cand + 1'b1);
  always_comb begin
    k_enc = '0;
    for (int j = 0; j < MaxTarget; j++) begin
      if (iso[j]) k_enc = k_enc | TvW'(j);
    end
  end

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = rdata_q;
    unique case (ctl_i.op)
      OP_ROW_RD:  raddr = {depth_q, visit_q[idx_p]};
      OP_NB_RD:   raddr = {depth_q, ctl_i.sub};
      OP_CH_RD:   raddr = {depth_q, vd};
      OP_COPY_RD: raddr = {depth_q, idx_p};
      OP_SEED: begin
        we    = 1'b1;
        waddr = {DepthW'(0), idx_p};
        wdata = seed_row;
      end
      OP_ROW_DONE: begin
        we    = row_changed;
        waddr = {depth_q, v_q};
        wdata = newrow;
      end
      OP_COPY_WR: begin
        we    = 1'b1;
        waddr = {DepthW'(depth_q + 1'b1), idx_p};
        wdata = (idx_p == vd) ? (rdata_q & (MaxTarget'(1) << k_q)) : rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // Control state and adjacency stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_cfg_q    <= PnW'(1);
      tn_cfg_q    <= TnW'(1);
      for (int i = 0; i < MaxPattern; i++) padj_q[i] <= '0;
      for (int i = 0; i < MaxTarget; i++) tadj_q[i] <= '0;
      used_q      <= '0;
      depth_q     <= '0;
      cur_none_q  <= 1'b1;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (ctl_i.op)
        OP_LOAD: begin
          if (cmd_i == CmdPatternEdge) begin
            active_q <= 1'b0;
            if (vertex_a_i != vertex_b_i && int'(vertex_a_i) < MaxPattern &&
                int'(vertex_b_i) < MaxPattern) begin
              padj_q[vertex_a_i[PvW-1:0]][vertex_b_i[PvW-1:0]] <= 1'b1;
              padj_q[vertex_b_i[PvW-1:0]][vertex_a_i[PvW-1:0]] <= 1'b1;
            end
          end else if (cmd_i == CmdTargetEdge) begin
            active_q <= 1'b0;
            if (vertex_a_i != vertex_b_i && int'(vertex_a_i) < MaxTarget &&
                int'(vertex_b_i) < MaxTarget) begin
              tadj_q[vertex_a_i[TvW-1:0]][vertex_b_i[TvW-1:0]] <= 1'b1;
              tadj_q[vertex_b_i[TvW-1:0]][vertex_a_i[TvW-1:0]] <= 1'b1;
            end
          end else if (cmd_i == CmdClear) begin
            active_q <= 1'b0;
            for (int i = 0; i < MaxPattern; i++) padj_q[i] <= '0;
            for (int i = 0; i < MaxTarget; i++) tadj_q[i] <= '0;
          end else if (cmd_i == CmdStart) begin
            used_q     <= '0;
            depth_q    <= '0;
            cur_none_q <= 1'b1;
            active_q   <= 1'b1;
          end
        end
        OP_BACK: begin
          if (depth_q != '0) begin
            used_q[back_c] <= 1'b0;
            cur_none_q     <= 1'b0;
            depth_q        <= back_d;
          end
        end
        OP_DESCEND: begin
          used_q[k_q] <= 1'b1;
          cur_none_q  <= 1'b1;
        end
        OP_DEPTH_INC: depth_q <= depth_q + 1'b1;
        OP_EMIT_EXH: if (out_free) active_q <= 1'b0;
        default: ;
      endcase

      if (cfg_write_i) begin
        active_q <= 1'b0;
        if (cfg_index_i == CfgPatternVertices) pn_cfg_q <= cfg_data_i[PnW-1:0];
        else pn_cfg_q <= pn_cfg_q;
        if (cfg_index_i == CfgTargetVertices) tn_cfg_q <= cfg_data_i[TnW-1:0];
      end

      if ((ctl_i.op == OP_EMIT_PAIR || ctl_i.op == OP_EMIT_EXH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers, loaded before they are read.
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      OP_LOAD: if (cmd_i == CmdStart) taken_q <= '0;
      OP_PDEG: pdeg_q[idx_p] <= pop_pattern(padj_q[idx_p] & pm);
      OP_TDEG: tdeg_q[ctl_i.idx] <= pop_target(tadj_q[ctl_i.idx] & tm);
      OP_ORD_INIT: have_q <= 1'b0;
      OP_ORD_STEP: begin
        if (!taken_q[ctl_i.sub] && (!have_q || pdeg_q[ctl_i.sub] > bdeg_q)) begin
          best_q <= ctl_i.sub;
          bdeg_q <= pdeg_q[ctl_i.sub];
          have_q <= 1'b1;
        end
      end
      OP_ORD_COMMIT: begin
        visit_q[idx_p]  <= best_q;
        taken_q[best_q] <= 1'b1;
      end
      OP_PASS_INIT: changed_q <= 1'b0;
      OP_ROW_RD: begin
        v_q  <= visit_q[idx_p];
        ok_q <= '1;
      end
      OP_ROW_LATCH: rowv_q <= rdata_q;
      OP_NB_ACC: if (nb[ctl_i.sub]) ok_q <= ok_q & okv;
      OP_ROW_DONE: if (row_changed) changed_q <= 1'b1;
      OP_CH_PICK: k_q <= k_enc;
      OP_BACK: if (depth_q != '0) cur_q <= back_c;
      OP_DESCEND: chosen_q[vd] <= k_q;
      OP_EMIT_PAIR: begin
        if (out_free) begin
          kind_q <= 1'b0;
          pv_q   <= OutPvW'(idx_p);
          tv_q   <= OutTvW'(chosen_q[idx_p]);
          last_q <= (ctl_i.idx == TvW'(pn_eff - 1'b1));
        end
      end
      OP_EMIT_EXH: begin
        if (out_free) begin
          kind_q <= 1'b1;
          pv_q   <= '0;
          tv_q   <= '0;
          last_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign status_o.pn          = pn_eff;
  assign status_o.tn          = tn_eff;
  assign status_o.depth       = depth_q;
  assign status_o.pn_gt_tn    = (TnW'(pn_eff) > tn_eff);
  assign status_o.active      = active_q;
  assign status_o.row_fail    = (newrow == '0);
  assign status_o.changed_any = changed_q || row_changed;
  assign status_o.k_found     = (depth_q < DepthW'(pn_eff)) && (cand != '0);
  assign status_o.last_level  = (depth_q == DepthW'(pn_eff - 1'b1));
  assign status_o.out_free    = out_free;

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign pattern_vertex_o = pv_q;
  assign target_vertex_o  = tv_q;
  assign last_o           = last_q;

endmodule
